// File: sv/assert_macros.svh
// Assertion helpers for the checker file zvc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

// File: sv/zvc_pkg.sv
`timescale 1ns / 1ps

package zvc_pkg;

   localparam int VALUE_WIDTH         = 64;
   localparam int BYTE_WIDTH          = 8;
   localparam int GROUP_BITS          = 7;
   localparam int GROUP_IDX_WIDTH     = 4;
   localparam int INT32_SIGN_BIT      = 31;
   localparam int DEFAULT_MAX_GROUPS  = 10;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ZIGZAG_MODE = '0;
   localparam logic                        ZIGZAG_MODE_RESET = 1'b1;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_BYTE  = 1'b0,
      KIND_VALUE = 1'b1
   } kind_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      cmd_type                command;
      logic [VALUE_WIDTH-1:0] value;
      logic [BYTE_WIDTH-1:0]  data_byte;
      logic                   payload_end;
   } entry_type;

endpackage

// File: sv/zvc_front.sv
`timescale 1ns / 1ps

module zvc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              zigzag_mode,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [zvc_pkg::VALUE_WIDTH-1:0]   req_value_in,
   input  logic [zvc_pkg::BYTE_WIDTH-1:0]    req_data_byte,
   input  logic                              req_payload_end,
   output logic                              push_valid,
   output zvc_pkg::entry_type                push_entry,
   input  logic                              push_ready
);
   import zvc_pkg::*;

   logic                   valid_ff, valid_in;
   entry_type              entry_ff, entry_in;
   logic [VALUE_WIDTH-1:0] mapped;
   logic                   accept;

   assign req_ready  = !valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      // zigzag: fold the sign into bit 0
      if (zigzag_mode) begin
         mapped = (req_value_in << 1) ^ {VALUE_WIDTH{req_value_in[VALUE_WIDTH-1]}};
      end else begin
         mapped = req_value_in;
      end
      entry_in.command     = cmd_type'(req_command);
      entry_in.value       = (cmd_type'(req_command) == CMD_ENCODE) ? mapped : '0;
      entry_in.data_byte   = req_data_byte;
      entry_in.payload_end = req_payload_end;

      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// File: sv/zvc_queue.sv
`timescale 1ns / 1ps

module zvc_queue #(
   parameter int DEPTH = zvc_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  zvc_pkg::entry_type push_entry,
   output logic               push_ready,
   output logic               pop_valid,
   output zvc_pkg::entry_type pop_entry,
   input  logic               pop_ready
);
   import zvc_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   entry_type             entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  push_fire, pop_fire;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] ptr);
      logic [PTR_WIDTH-1:0] result;
      if (ptr == PTR_WIDTH'(DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

   assign push_ready = (count_ff != CNT_WIDTH'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      unique case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/zvc_back.sv
`timescale 1ns / 1ps

module zvc_back #(
   parameter int MAX_GROUPS = zvc_pkg::DEFAULT_MAX_GROUPS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            zigzag_mode,
   input  logic                            pop_valid,
   input  zvc_pkg::entry_type              pop_entry,
   output logic                            pop_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_result_kind,
   output logic [zvc_pkg::BYTE_WIDTH-1:0]  rsp_out_byte,
   output logic [zvc_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   output logic                            rsp_fits_32,
   output logic                            rsp_last_of_run
);
   import zvc_pkg::*;

   localparam int ENC_WIDTH   = VALUE_WIDTH - GROUP_BITS;
   localparam int SHIFT_WIDTH = $clog2(GROUP_BITS * (1 << GROUP_IDX_WIDTH));

   typedef enum logic {
      ST_FETCH,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   kind_type                   kind_ff, kind_in;
   logic [BYTE_WIDTH-1:0]      byte_ff, byte_in;
   logic [VALUE_WIDTH-1:0]     value_ff, value_in;
   logic                       fits_ff, fits_in;
   logic                       last_ff, last_in;
   logic [ENC_WIDTH-1:0]       enc_ff, enc_in;
   logic [VALUE_WIDTH-1:0]     acc_ff, acc_in;
   logic [GROUP_IDX_WIDTH-1:0] group_ff, group_in;
   logic                       done_ff, done_in;

   logic                       slot_free;
   logic                       group_ok;
   logic [SHIFT_WIDTH-1:0]     shamt;
   logic [VALUE_WIDTH-1:0]     acc_next;
   logic [VALUE_WIDTH-1:0]     decoded;
   logic                       decoded_fits;
   logic                       enc_more;
   logic                       first_more;

   assign slot_free       = !rsp_valid_ff || rsp_ready;
   assign pop_ready       = (state_ff == ST_FETCH) && slot_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_out_value   = value_ff;
   assign rsp_fits_32     = fits_ff;
   assign rsp_last_of_run = last_ff;

   always_comb begin
      group_ok = group_ff < GROUP_IDX_WIDTH'(MAX_GROUPS);
      shamt    = SHIFT_WIDTH'(group_ff) * SHIFT_WIDTH'(GROUP_BITS);
      // groups sit in disjoint bit ranges, so OR adds them
      acc_next = acc_ff;
      if (group_ok) begin
         acc_next = acc_ff
                  | (VALUE_WIDTH'(pop_entry.data_byte[GROUP_BITS-1:0]) << shamt);
      end
      if (zigzag_mode) begin
         decoded      = (acc_next >> 1) ^ {VALUE_WIDTH{acc_next[0]}};
         decoded_fits = (&decoded[VALUE_WIDTH-1:INT32_SIGN_BIT])
                     || !(|decoded[VALUE_WIDTH-1:INT32_SIGN_BIT]);
      end else begin
         decoded      = acc_next;
         decoded_fits = 1'b0;
      end
      enc_more   = |enc_ff[ENC_WIDTH-1:GROUP_BITS];
      first_more = |pop_entry.value[VALUE_WIDTH-1:GROUP_BITS];

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      value_in     = value_ff;
      fits_in      = fits_ff;
      last_in      = last_ff;
      enc_in       = enc_ff;
      acc_in       = acc_ff;
      group_in     = group_ff;
      done_in      = done_ff;

      unique case (state_ff)
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_BYTE;
               byte_in      = {enc_more, enc_ff[GROUP_BITS-1:0]};
               value_in     = '0;
               fits_in      = 1'b0;
               last_in      = !enc_more;
               enc_in       = ENC_WIDTH'(enc_ff >> GROUP_BITS);
               if (!enc_more) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            if (pop_valid && slot_free) begin
               if (pop_entry.command == CMD_ENCODE) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_BYTE;
                  byte_in      = {first_more, pop_entry.value[GROUP_BITS-1:0]};
                  value_in     = '0;
                  fits_in      = 1'b0;
                  last_in      = !first_more;
                  enc_in       = pop_entry.value[VALUE_WIDTH-1:GROUP_BITS];
                  if (first_more) begin
                     state_in = ST_EMIT;
                  end
               end else if (done_ff) begin
                  // drop trailing words until the payload ends
                  if (pop_entry.payload_end) begin
                     acc_in   = '0;
                     group_in = '0;
                     done_in  = 1'b0;
                  end
               end else if (!pop_entry.data_byte[BYTE_WIDTH-1] || pop_entry.payload_end) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_VALUE;
                  byte_in      = '0;
                  value_in     = decoded;
                  fits_in      = decoded_fits;
                  last_in      = 1'b1;
                  acc_in       = '0;
                  group_in     = '0;
                  done_in      = !pop_entry.payload_end;
               end else begin
                  acc_in = acc_next;
                  if (group_ok) begin
                     group_in = group_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         group_ff     <= '0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         group_ff     <= group_in;
         done_ff      <= done_in;
      end
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      value_ff <= value_in;
      fits_ff  <= fits_in;
      last_ff  <= last_in;
      enc_ff   <= enc_in;
   end

endmodule

// File: sv/zigzag_varint_codec_unit.sv
`timescale 1ns / 1ps
// Base-128 varint encoder and decoder with optional zigzag signed mapping.
// Request channel (req_*): command 0 encodes req_value_in into 1 to 10
// words on the response channel, least significant group first, bit 7 set
// while more follow. Command 1 feeds one payload byte to the decoder; the
// decoded value comes out as one word at the first byte with bit 7 clear,
// or at the byte flagged req_payload_end. Later bytes of that payload
// give nothing. rsp_fits_32 flags a zigzag-decoded signed value that fits 32 bits.
// Configuration (csr_*): register 0 at address 0, bit 0 = zigzag mode.
// A request passes the front register and the queue before its first
// response word is registered. The back end emits one word per cycle
// while the response side takes them, one per encoded byte and at most
// one per decode byte, so decode runs at one byte per cycle. The front
// register and a small queue let requests keep flowing while the back
// end works or the response side stalls; a stalled word holds until taken.
// Reset clears the decoder state, the queue and the response register,
// and sets zigzag mode to 1. No clearing pass is needed.

module zigzag_varint_codec_unit #(
   parameter int MAX_GROUPS  = zvc_pkg::DEFAULT_MAX_GROUPS,
   parameter int QUEUE_DEPTH = zvc_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [zvc_pkg::VALUE_WIDTH-1:0]    req_value_in,
   input  logic [zvc_pkg::BYTE_WIDTH-1:0]     req_data_byte,
   input  logic                               req_payload_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_result_kind,
   output logic [zvc_pkg::BYTE_WIDTH-1:0]     rsp_out_byte,
   output logic [zvc_pkg::VALUE_WIDTH-1:0]    rsp_out_value,
   output logic                               rsp_fits_32,
   output logic                               rsp_last_of_run,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [zvc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [zvc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [zvc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import zvc_pkg::*;

   logic                       mode_ff, mode_in;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic                       csr_write;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_ZIGZAG_MODE) ? CSR_DATA_WIDTH'(mode_ff) : '0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && (csr_index == REG_ZIGZAG_MODE)) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ZIGZAG_MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   zvc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .zigzag_mode     (mode_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_value_in    (req_value_in),
      .req_data_byte   (req_data_byte),
      .req_payload_end (req_payload_end),
      .push_valid      (push_valid),
      .push_entry      (push_entry),
      .push_ready      (push_ready)
   );

   zvc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   zvc_back #(
      .MAX_GROUPS (MAX_GROUPS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .zigzag_mode     (mode_ff),
      .pop_valid       (pop_valid),
      .pop_entry       (pop_entry),
      .pop_ready       (pop_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_value   (rsp_out_value),
      .rsp_fits_32     (rsp_fits_32),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: sv/zvc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zvc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_result_kind,
   input logic [zvc_pkg::BYTE_WIDTH-1:0]  rsp_out_byte,
   input logic [zvc_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   input logic                            rsp_fits_32,
   input logic                            rsp_last_of_run
);
   import zvc_pkg::*;

   logic stalled;
   logic byte_word, byte_ok;
   logic value_word, value_ok;

   assign stalled    = rsp_valid && !rsp_ready;
   assign byte_word  = rsp_valid && (rsp_result_kind == KIND_BYTE);
   // encoded word: continuation bit is the inverse of last, other fields clear
   assign byte_ok    = (rsp_out_byte[BYTE_WIDTH-1] == !rsp_last_of_run)
                       && (rsp_out_value == '0) && !rsp_fits_32;
   assign value_word = rsp_valid && (rsp_result_kind == KIND_VALUE);
   // decoded word: always ends its run, byte field clear
   assign value_ok   = rsp_last_of_run && (rsp_out_byte == '0);

   // a stalled word stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, stalled |=> rsp_valid, "stalled word dropped")

   `ASSERT_CLK(a_byte_word, clock, reset, byte_word |-> byte_ok, "malformed encoded word")

   `ASSERT_CLK(a_value_word, clock, reset, value_word |-> value_ok, "malformed decoded word")

   // nothing offered right after reset
   `ASSERT_NEVER(a_reset_quiet, clock, reset, $past(reset) && rsp_valid, "valid after reset")

endmodule

bind zigzag_varint_codec_unit zvc_checker u_checker (.*);
